### sv/per_class_box_suppression_assert.svh
// Assertion macros shared by the per-class box suppression RTL.
`ifndef PER_CLASS_BOX_SUPPRESSION_ASSERT_SVH
`define PER_CLASS_BOX_SUPPRESSION_ASSERT_SVH
// Same-cycle implication, sampled on clk, disabled while rst is high.
`define PCBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("per_class_box_suppression: same-cycle check failed");
// Next-cycle implication, sampled on clk, disabled while rst is high.
`define PCBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("per_class_box_suppression: next-cycle check failed");
`endif

### sv/pcbs_pkg.sv
// Types and constants shared by the per-class box suppression block.
package pcbs_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_IOU   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCORE = 2'd1;

  localparam logic [15:0] IOU_RESET   = 16'd26214;
  localparam logic [15:0] SCORE_RESET = 16'd32768;

  typedef struct packed {
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } box_t;

  typedef struct packed {
    logic [15:0] class_score;
    logic [6:0]  cls;
    logic [15:0] obj;
    box_t        box;
  } det_t;

  typedef struct packed {
    logic done;
    logic hit;
  } ov_stat_t;

endpackage

### sv/pcbs_if.sv
// Channel interfaces: candidate input, kept-box output and register writes.
interface pcbs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [15:0] box_w;
  logic [15:0] box_h;
  logic [15:0] objectness;
  logic [6:0]  class_index;
  logic [15:0] class_score;
  logic        last_in;
  modport source (output valid, center_x, center_y, box_w, box_h, objectness,
                  class_index, class_score, last_in, input ready);
  modport sink (input valid, center_x, center_y, box_w, box_h, objectness,
                class_index, class_score, last_in, output ready);
endinterface

interface pcbs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] kept_x;
  logic [15:0] kept_y;
  logic [15:0] kept_w;
  logic [15:0] kept_h;
  logic [15:0] kept_objectness;
  logic [6:0]  kept_class;
  logic [15:0] kept_class_score;
  logic        empty_set;
  logic        overflowed;
  logic        last_out;
  modport source (output valid, kept_x, kept_y, kept_w, kept_h, kept_objectness,
                  kept_class, kept_class_score, empty_set, overflowed, last_out,
                  input ready);
  modport sink (input valid, kept_x, kept_y, kept_w, kept_h, kept_objectness,
                kept_class, kept_class_score, empty_set, overflowed, last_out,
                output ready);
endinterface

interface pcbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [15:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

### sv/pcbs_ram.sv
// Generic simple dual-port RAM with registered read data.
module pcbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/pcbs_overlap.sv
// Multi-cycle overlap test around one shared multiplier.
module pcbs_overlap
  import pcbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] thr,
  input  box_t        box_a,
  input  box_t        box_b,
  output ov_stat_t    stat
);

  typedef enum logic [8:0] {
    OV_IDLE = 9'b000000001,
    OV_EDGE = 9'b000000010,
    OV_MI   = 9'b000000100,
    OV_MA   = 9'b000001000,
    OV_MB   = 9'b000010000,
    OV_SUM  = 9'b000100000,
    OV_ML   = 9'b001000000,
    OV_MH   = 9'b010000000,
    OV_CMP  = 9'b100000000
  } ov_state_t;

  ov_state_t   state;
  box_t        a;
  box_t        b;
  logic [15:0] thr_r;
  logic [18:0] ix;
  logic [18:0] iy;
  logic        pos;
  logic [34:0] i4;
  logic [33:0] acc;
  logic [35:0] u4;
  logic [37:0] lo;
  logic [37:0] mul_r;
  logic [18:0] mul_a;
  logic [18:0] mul_b;
  logic        done;
  logic        hit;

  logic signed [19:0] ax_hi, ax_lo, bx_hi, bx_lo, ay_hi, ay_lo, by_hi, by_lo;
  logic signed [19:0] ix_s, iy_s;
  logic [33:0] area_sum;
  logic [35:0] quad;
  logic [57:0] prod;
  logic [57:0] lhs;

  // Edges in doubled units, so halving the width is exact.
  always_comb begin
    ax_hi = $signed(20'({a.x, 1'b0})) + $signed(20'(a.w));
    ax_lo = $signed(20'({a.x, 1'b0})) - $signed(20'(a.w));
    bx_hi = $signed(20'({b.x, 1'b0})) + $signed(20'(b.w));
    bx_lo = $signed(20'({b.x, 1'b0})) - $signed(20'(b.w));
    ay_hi = $signed(20'({a.y, 1'b0})) + $signed(20'(a.h));
    ay_lo = $signed(20'({a.y, 1'b0})) - $signed(20'(a.h));
    by_hi = $signed(20'({b.y, 1'b0})) + $signed(20'(b.h));
    by_lo = $signed(20'({b.y, 1'b0})) - $signed(20'(b.h));
    ix_s  = ((ax_hi < bx_hi) ? ax_hi : bx_hi) - ((ax_lo > bx_lo) ? ax_lo : bx_lo);
    iy_s  = ((ay_hi < by_hi) ? ay_hi : by_hi) - ((ay_lo > by_lo) ? ay_lo : by_lo);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      OV_MI: begin
        mul_a = ix;
        mul_b = iy;
      end
      OV_MA: begin
        mul_a = 19'(a.w);
        mul_b = 19'(a.h);
      end
      OV_MB: begin
        mul_a = 19'(b.w);
        mul_b = 19'(b.h);
      end
      OV_ML: begin
        mul_a = 19'(thr_r);
        mul_b = u4[18:0];
      end
      OV_MH: begin
        mul_a = 19'(thr_r);
        mul_b = 19'(u4[35:19]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign area_sum = acc + 34'(mul_r[31:0]);
  assign quad     = {area_sum, 2'b00};
  assign prod     = {1'b0, mul_r, 19'b0} + 58'(lo);
  assign lhs      = 58'({i4, 16'b0});

  always_ff @(posedge clk) begin
    mul_r <= 38'(mul_a) * 38'(mul_b);
    if (rst) begin
      state <= OV_IDLE;
      done  <= 1'b0;
      hit   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        OV_IDLE: begin
          if (start) begin
            a     <= box_a;
            b     <= box_b;
            thr_r <= thr;
            state <= OV_EDGE;
          end
        end
        OV_EDGE: begin
          ix    <= ix_s[18:0];
          iy    <= iy_s[18:0];
          pos   <= (ix_s > 20'sd0) && (iy_s > 20'sd0);
          state <= OV_MI;
        end
        OV_MI:  state <= OV_MA;
        OV_MA: begin
          i4    <= mul_r[34:0];
          state <= OV_MB;
        end
        OV_MB: begin
          acc   <= 34'(mul_r[31:0]);
          state <= OV_SUM;
        end
        OV_SUM: begin
          u4    <= (quad > 36'(i4)) ? quad - 36'(i4) : '0;
          state <= OV_ML;
        end
        OV_ML:  state <= OV_MH;
        OV_MH: begin
          lo    <= mul_r;
          state <= OV_CMP;
        end
        OV_CMP: begin
          hit   <= pos && (lhs > prod);
          done  <= 1'b1;
          state <= OV_IDLE;
        end
        default: state <= OV_IDLE;
      endcase
    end
  end

  assign stat.done = done;
  assign stat.hit  = hit;

endmodule

### sv/per_class_box_suppression.sv
// Top level of the per-class box suppression block.
//
// Candidates arrive as beats on det_in, one per cycle while the block loads a
// frame. A beat whose objectness exceeds score_threshold and whose class is in
// range is written to the detection RAM if it has room; the beat with last_in
// closes the frame. Kept boxes then leave on det_out in ascending class order,
// best objectness first within a class, and the final beat carries last_out. A
// frame with no survivor yields one beat with empty_set set. Registers are
// written on cfg (address 0 iou_threshold, 1 score_threshold); the user must
// write them only while the block is idle, which the block does not enforce.
// After the last beat, each selection pass reads and checks the stored
// candidates one by one, and each suppression pass reads them again and tests
// each remaining same-class candidate against the kept box on the shared
// overlap multiplier. Every kept box costs one selection and one suppression
// pass. det_in is not ready meanwhile.
// An output register holds each result; if the receiver stalls, the sequencer
// waits before it pushes the next one. Reset empties the frame and restores
// the register defaults; the RAM needs no clearing.
`include "per_class_box_suppression_assert.svh"

module per_class_box_suppression
  import pcbs_pkg::*;
#(
  parameter int MAX_DETS    = 64,
  parameter int CLASS_COUNT = 80
) (
  input  logic        clk,
  input  logic        rst,
  pcbs_in_if.sink     det_in,
  pcbs_out_if.source  det_out,
  pcbs_cfg_if.sink    cfg
);

  localparam int AW = $clog2(MAX_DETS);
  localparam int CW = $clog2(MAX_DETS + 1);

  // One-hot sequencer: load, then alternate selection and suppression passes.
  typedef enum logic [6:0] {
    LOAD     = 7'b0000001,
    SEL_RD   = 7'b0000010,
    SEL_CHK  = 7'b0000100,
    SEL_END  = 7'b0001000,
    SUP_RD   = 7'b0010000,
    SUP_CHK  = 7'b0100000,
    SUP_WAIT = 7'b1000000
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       idx;
  logic [MAX_DETS-1:0] done_mask;
  logic                ovf;
  logic [15:0]         iou_thr;
  logic [15:0]         score_thr;
  det_t                best;
  logic [AW-1:0]       best_idx;
  logic                found;
  det_t                pend;
  logic                pend_v;

  // Output register.
  logic out_v;
  det_t out_det;
  logic out_empty;
  logic out_ovf;
  logic out_last;

  det_t     in_det;
  det_t     rdata;
  logic     accept;
  logic     pass;
  logic     store_ok;
  logic     out_free;
  logic     ov_start;
  ov_stat_t ov;
  logic     better;
  logic     push;
  logic     push_last;
  logic     push_empty;
  det_t     push_det;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iou_thr   <= IOU_RESET;
      score_thr <= SCORE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_IOU:   iou_thr   <= cfg.data;
        REG_SCORE: score_thr <= cfg.data;
        default:   ;
      endcase
    end
  end

  assign in_det.box.x       = det_in.center_x;
  assign in_det.box.y       = det_in.center_y;
  assign in_det.box.w       = det_in.box_w;
  assign in_det.box.h       = det_in.box_h;
  assign in_det.obj         = det_in.objectness;
  assign in_det.cls         = det_in.class_index;
  assign in_det.class_score = det_in.class_score;

  assign det_in.ready = (state == LOAD);
  assign accept       = det_in.valid && det_in.ready;
  assign pass         = (det_in.objectness > score_thr) &&
                        ({1'b0, det_in.class_index} < 8'(CLASS_COUNT));
  assign store_ok     = pass && (count < CW'(MAX_DETS));
  assign out_free     = !out_v || det_out.ready;

  pcbs_ram #(
    .WIDTH ($bits(det_t)),
    .DEPTH (MAX_DETS)
  ) u_store (
    .clk   (clk),
    .we    (accept && store_ok),
    .waddr (count[AW-1:0]),
    .wdata (in_det),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign ov_start = (state == SUP_CHK) && !done_mask[idx[AW-1:0]] &&
                    (rdata.cls == pend.cls);

  pcbs_overlap u_overlap (
    .clk   (clk),
    .rst   (rst),
    .start (ov_start),
    .thr   (iou_thr),
    .box_a (pend.box),
    .box_b (rdata.box),
    .stat  (ov)
  );

  // Ranking key: lower class first, then higher objectness; the scan runs in
  // arrival order, so an equal score never displaces the earlier box.
  assign better = (rdata.cls < best.cls) ||
                  ((rdata.cls == best.cls) && (rdata.obj > best.obj));

  // A kept box waits in pend until the next selection pass tells whether it
  // is the last of the frame.
  always_comb begin
    push       = 1'b0;
    push_last  = 1'b0;
    push_empty = 1'b0;
    push_det   = pend;
    if (state == SEL_END) begin
      if (found) begin
        push = pend_v && out_free;
      end else if (out_free) begin
        push       = 1'b1;
        push_last  = 1'b1;
        push_empty = !pend_v;
        push_det   = pend_v ? pend : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (push) begin
      out_v <= 1'b1;
    end else if (det_out.ready) begin
      out_v <= 1'b0;
    end
    if (push) begin
      out_det   <= push_det;
      out_empty <= push_empty;
      out_last  <= push_last;
      out_ovf   <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      count     <= '0;
      idx       <= '0;
      done_mask <= '0;
      ovf       <= 1'b0;
      found     <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (accept) begin
            if (store_ok) begin
              count <= count + 1'b1;
            end
            if (pass && !store_ok) begin
              ovf <= 1'b1;
            end
            if (det_in.last_in) begin
              idx   <= '0;
              found <= 1'b0;
              state <= SEL_RD;
            end
          end
        end
        SEL_RD: begin
          state <= (idx == count) ? SEL_END : SEL_CHK;
        end
        SEL_CHK: begin
          if (!done_mask[idx[AW-1:0]] && (!found || better)) begin
            best     <= rdata;
            best_idx <= idx[AW-1:0];
            found    <= 1'b1;
          end
          idx   <= idx + 1'b1;
          state <= SEL_RD;
        end
        SEL_END: begin
          if (found) begin
            if (!pend_v || out_free) begin
              pend                <= best;
              pend_v              <= 1'b1;
              done_mask[best_idx] <= 1'b1;
              idx                 <= '0;
              state               <= SUP_RD;
            end
          end else if (out_free) begin
            pend_v    <= 1'b0;
            count     <= '0;
            done_mask <= '0;
            ovf       <= 1'b0;
            state     <= LOAD;
          end
        end
        SUP_RD: begin
          if (idx == count) begin
            idx   <= '0;
            found <= 1'b0;
            state <= SEL_RD;
          end else begin
            state <= SUP_CHK;
          end
        end
        SUP_CHK: begin
          if (ov_start) begin
            state <= SUP_WAIT;
          end else begin
            idx   <= idx + 1'b1;
            state <= SUP_RD;
          end
        end
        SUP_WAIT: begin
          if (ov.done) begin
            if (ov.hit) begin
              done_mask[idx[AW-1:0]] <= 1'b1;
            end
            idx   <= idx + 1'b1;
            state <= SUP_RD;
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  assign det_out.valid            = out_v;
  assign det_out.kept_x           = out_det.box.x;
  assign det_out.kept_y           = out_det.box.y;
  assign det_out.kept_w           = out_det.box.w;
  assign det_out.kept_h           = out_det.box.h;
  assign det_out.kept_objectness  = out_det.obj;
  assign det_out.kept_class       = out_det.cls;
  assign det_out.kept_class_score = out_det.class_score;
  assign det_out.empty_set        = out_empty;
  assign det_out.overflowed       = out_ovf;
  assign det_out.last_out         = out_last;

  // The fill count never passes the store depth.
  `PCBS_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(MAX_DETS))
  // The empty marker is always the final beat of its frame.
  `PCBS_ASSERT_NOW(a_empty_last, out_v && out_empty, out_last)
  // Closing a frame leaves the store empty and the block loading.
  `PCBS_ASSERT_NEXT(a_frame_close, (state == SEL_END) && !found && out_free,
                    (state == LOAD) && (count == '0) && !ovf)

endmodule
